// ===== rtl/tvsns_pkg.sv =====
// shared types and constants for the three voice square and noise synth
package tvsns_pkg;

    localparam int unsigned ENV_TOP     = 32000;
    localparam int unsigned ENV_RECIP   = 33555;
    localparam int unsigned ENV_SHIFT   = 25;
    localparam int unsigned PHASE_INC   = 100;
    localparam int unsigned VOL_MAX     = 10;
    localparam int unsigned STEP_BASE   = 64;
    localparam int unsigned NOTE_RESET  = 60;
    localparam logic [16:0] NOISE_SEED  = 17'h1bac;
    localparam logic [3:0]  ST_NOTE_OFF = 4'h8;
    localparam logic [3:0]  ST_NOTE_ON  = 4'h9;
    localparam logic [3:0]  ST_CONTROL  = 4'hb;
    localparam logic [6:0]  CC_ENV_STEP = 7'd80;
    localparam logic [6:0]  CC_NOISE    = 7'd81;
    localparam int unsigned DIV_W       = 20;

    localparam logic [19:0] PITCH_ROM [0:127] = '{
        20'd539397, 20'd509123, 20'd480548, 20'd453577, 20'd428120, 20'd404091,
        20'd381411, 20'd360004, 20'd339799, 20'd320727, 20'd302726, 20'd285736,
        20'd269698, 20'd254561, 20'd240274, 20'd226788, 20'd214060, 20'd202046,
        20'd190706, 20'd180002, 20'd169899, 20'd160364, 20'd151363, 20'd142868,
        20'd134849, 20'd127281, 20'd120137, 20'd113394, 20'd107030, 20'd101023,
        20'd95353, 20'd90001, 20'd84950, 20'd80182, 20'd75682, 20'd71434,
        20'd67425, 20'd63640, 20'd60068, 20'd56697, 20'd53515, 20'd50511,
        20'd47676, 20'd45001, 20'd42475, 20'd40091, 20'd37841, 20'd35717,
        20'd33712, 20'd31820, 20'd30034, 20'd28349, 20'd26757, 20'd25256,
        20'd23838, 20'd22500, 20'd21237, 20'd20045, 20'd18920, 20'd17858,
        20'd16856, 20'd15910, 20'd15017, 20'd14174, 20'd13379, 20'd12628,
        20'd11919, 20'd11250, 20'd10619, 20'd10023, 20'd9460, 20'd8929,
        20'd8428, 20'd7955, 20'd7509, 20'd7087, 20'd6689, 20'd6314,
        20'd5960, 20'd5625, 20'd5309, 20'd5011, 20'd4730, 20'd4465,
        20'd4214, 20'd3978, 20'd3754, 20'd3544, 20'd3345, 20'd3157,
        20'd2980, 20'd2813, 20'd2655, 20'd2506, 20'd2365, 20'd2232,
        20'd2107, 20'd1989, 20'd1877, 20'd1772, 20'd1672, 20'd1578,
        20'd1490, 20'd1406, 20'd1327, 20'd1253, 20'd1183, 20'd1116,
        20'd1054, 20'd994, 20'd939, 20'd886, 20'd836, 20'd789,
        20'd745, 20'd703, 20'd664, 20'd626, 20'd591, 20'd558,
        20'd527, 20'd497, 20'd469, 20'd443, 20'd418, 20'd395,
        20'd372, 20'd352
    };

    typedef struct packed {
        logic load;
        logic ev_apply;
        logic voice_clr;
        logic noise_start;
        logic tone_start;
        logic voice_upd;
        logic mul1;
        logic mul2;
        logic acc;
        logic scale;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_tick;
        logic vol_zero;
        logic div_done;
        logic last_voice;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/tvsns_div.sv =====
// shared restoring divider, one quotient bit per cycle, remainder only
module tvsns_div import tvsns_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_rem
);

    localparam int CW = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_rem, r_dvd, r_dsr;
    logic [CW-1:0]    r_cnt;
    logic             r_done;
    logic [DIV_W:0]   n_trial;

    assign n_trial = {r_rem, r_dvd[DIV_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CW'(DIV_W);
            r_done <= 1'b0;
            r_rem  <= '0;
            r_dvd  <= i_dividend;
            r_dsr  <= i_divisor;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
            r_dvd <= {r_dvd[DIV_W-2:0], 1'b0};
            if (n_trial >= {1'b0, r_dsr}) begin
                r_rem <= DIV_W'(n_trial - {1'b0, r_dsr});
            end else begin
                r_rem <= n_trial[DIV_W-1:0];
            end
            r_done <= (r_cnt == CW'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/tvsns_ctrl.sv =====
// sequencer for event decode and the per-voice tick pass
module tvsns_ctrl import tvsns_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_NSTART, S_NWAIT, S_TSTART, S_TWAIT,
        S_VUPD, S_MUL1, S_MUL2, S_ACC, S_SCALE, S_OUT
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE:   if (i_in_valid) r_state <= S_DECODE;
                S_DECODE: begin
                    priority if (!i_sts.is_tick) r_state <= S_IDLE;
                    else if (i_sts.vol_zero)     r_state <= S_SCALE;
                    else                         r_state <= S_NSTART;
                end
                S_NSTART: r_state <= S_NWAIT;
                S_NWAIT:  if (i_sts.div_done) r_state <= S_TSTART;
                S_TSTART: r_state <= S_TWAIT;
                S_TWAIT:  if (i_sts.div_done) r_state <= S_VUPD;
                S_VUPD:   r_state <= S_MUL1;
                S_MUL1:   r_state <= S_MUL2;
                S_MUL2:   r_state <= S_ACC;
                S_ACC:    r_state <= i_sts.last_voice ? S_SCALE : S_NSTART;
                S_SCALE:  r_state <= S_OUT;
                S_OUT:    if (i_sts.out_free) r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd             = '0;
        o_cmd.load        = (r_state == S_IDLE) && i_in_valid;
        o_cmd.ev_apply    = (r_state == S_DECODE) && !i_sts.is_tick;
        o_cmd.voice_clr   = (r_state == S_DECODE);
        o_cmd.noise_start = (r_state == S_NSTART);
        o_cmd.tone_start  = (r_state == S_TSTART);
        o_cmd.voice_upd   = (r_state == S_VUPD);
        o_cmd.mul1        = (r_state == S_MUL1);
        o_cmd.mul2        = (r_state == S_MUL2);
        o_cmd.acc         = (r_state == S_ACC);
        o_cmd.scale       = (r_state == S_SCALE);
        o_cmd.out_load    = (r_state == S_OUT) && i_sts.out_free;
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== rtl/tvsns_dp.sv =====
// voice state, mixer and output register
module tvsns_dp import tvsns_pkg::*; #(
    parameter int VOICES        = 3,
    parameter int PITCH_ENTRIES = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_data,
    input  logic               i_cmd_bit,
    input  logic [7:0]         i_midi_status,
    input  logic [6:0]         i_midi_data1,
    input  logic [6:0]         i_midi_data2,
    input  logic [11:0]        i_sample_index,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_sample
);

    localparam int VW   = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int MIXW = $clog2(992 * VOICES + 1) + 1;
    localparam int SCW  = MIXW + 5;

    logic [6:0]  r_vel   [VOICES];
    logic signed [7:0] r_step [VOICES];
    logic [14:0] r_lvl   [VOICES];
    logic [8:0]  r_np    [VOICES];
    logic [16:0] r_nreg  [VOICES];
    logic [19:0] r_phase [VOICES];
    logic [19:0] r_per   [VOICES];

    logic [3:0]  r_vol;
    logic        r_tick;
    logic [7:0]  r_status;
    logic [6:0]  r_d1, r_d2;
    logic [11:0] r_idx;
    logic [VW-1:0] r_v;
    logic        r_noise_hit;
    logic        r_neg;
    logic [14:0] r_lvl_new;
    logic [4:0]  r_vel4;
    logic [5:0]  r_q;
    logic signed [10:0] r_term;
    logic signed [MIXW-1:0] r_mix;
    logic signed [SCW-1:0]  r_scaled;

    logic        div_start, div_done, div_noise;
    logic [19:0] div_dvd, div_dsr, div_rem;
    logic [VW-1:0] ev_v;
    logic [6:0]  note_sat;
    logic signed [16:0] env_next;
    logic [16:0] nreg_step, nreg_new;
    logic        neg_new;
    logic [30:0] q_prod;
    logic [9:0]  p_prod;
    logic signed [31:0] sc32;
    logic [3:0]  vol_eff;

    assign div_start = i_cmd.noise_start | i_cmd.tone_start;
    assign div_noise = i_cmd.noise_start;
    assign div_dvd   = div_noise ? {8'd0, r_idx} : (r_phase[r_v] + 20'(PHASE_INC));
    assign div_dsr   = div_noise ? {11'd0, r_np[r_v]} : r_per[r_v];

    tvsns_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // channel to voice map, one entry per channel number
    always_comb begin
        ev_v = '0;
        for (int s = 0; s < 16; s++) begin
            if (r_status[3:0] == 4'(s)) ev_v = VW'(s % VOICES);
        end
    end

    assign note_sat = (32'(r_d1) >= PITCH_ENTRIES) ? 7'(PITCH_ENTRIES - 1) : r_d1;
    assign env_next = $signed({2'b00, r_lvl[r_v]}) + 17'(r_step[r_v]);
    assign nreg_step = (r_nreg[r_v] >> 1) ^ {r_nreg[r_v][0], 2'b00, r_nreg[r_v][0], 13'd0};
    assign nreg_new  = r_noise_hit ? nreg_step : r_nreg[r_v];
    assign neg_new   = (r_np[r_v] == '0) ? !(div_rem < (r_per[r_v] >> 1)) : !nreg_new[0];
    assign q_prod    = 31'(r_lvl_new) * 31'(ENV_RECIP);
    assign p_prod    = 10'(r_q * r_vel4);
    assign sc32      = 32'(r_scaled);
    assign vol_eff   = (32'(r_vol) > VOL_MAX) ? 4'(VOL_MAX) : r_vol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol       <= 4'd5;
            o_out_valid <= 1'b0;
            for (int i = 0; i < VOICES; i++) begin
                r_vel[i]   <= '0;
                r_step[i]  <= '0;
                r_lvl[i]   <= '0;
                r_np[i]    <= '0;
                r_nreg[i]  <= NOISE_SEED;
                r_phase[i] <= '0;
                r_per[i]   <= PITCH_ROM[(NOTE_RESET >= PITCH_ENTRIES) ?
                                        PITCH_ENTRIES - 1 : NOTE_RESET];
            end
        end else begin
            if (i_cfg_we) r_vol <= i_cfg_data;
            if (i_cmd.load) begin
                r_tick   <= i_cmd_bit;
                r_status <= i_midi_status;
                r_d1     <= i_midi_data1;
                r_d2     <= i_midi_data2;
                r_idx    <= i_sample_index;
                r_mix    <= '0;
            end
            if (i_cmd.ev_apply) begin
                unique case (r_status[7:4])
                    ST_NOTE_OFF: r_vel[ev_v] <= '0;
                    ST_NOTE_ON: begin
                        if (r_d2 != '0) begin
                            r_lvl[ev_v] <= r_step[ev_v][7] ? 15'(ENV_TOP) : 15'd0;
                            r_per[ev_v] <= PITCH_ROM[note_sat];
                        end
                        r_vel[ev_v] <= r_d2;
                    end
                    ST_CONTROL: begin
                        priority if (r_d1 == CC_ENV_STEP)
                            r_step[ev_v] <= 8'(STEP_BASE) - {1'b0, r_d2};
                        else if (r_d1 == CC_NOISE)
                            r_np[ev_v] <= {r_d2, 2'b00};
                    end
                    default: ;
                endcase
            end
            if (i_cmd.voice_clr) r_v <= '0;
            // noise divider result still held when the tone pass starts
            if (i_cmd.tone_start) r_noise_hit <= (r_np[r_v] != '0) && (div_rem == '0);
            if (i_cmd.voice_upd) begin
                r_phase[r_v] <= div_rem;
                r_nreg[r_v]  <= nreg_new;
                r_neg        <= neg_new;
                r_vel4       <= r_vel[r_v][6:2];
                if (!env_next[16] && (env_next <= 17'sd32000) && (r_idx[1:0] == 2'b00)) begin
                    r_lvl[r_v]  <= env_next[14:0];
                    r_lvl_new   <= env_next[14:0];
                end else begin
                    r_lvl_new   <= r_lvl[r_v];
                end
            end
            if (i_cmd.mul1) r_q <= 6'(q_prod >> ENV_SHIFT);
            if (i_cmd.mul2) r_term <= r_neg ? -$signed({1'b0, p_prod}) : $signed({1'b0, p_prod});
            if (i_cmd.acc) begin
                r_mix <= r_mix + MIXW'(r_term);
                r_v   <= r_v + 1'b1;
            end
            if (i_cmd.scale) r_scaled <= SCW'(r_mix * $signed({1'b0, vol_eff}));
            if (i_cmd.out_load) begin
                o_out_valid <= 1'b1;
                priority if (sc32 > 32'sd32767)   o_sample <= 16'sh7fff;
                else if (sc32 < -32'sd32768)      o_sample <= 16'sh8000;
                else                              o_sample <= sc32[15:0];
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.is_tick    = r_tick;
    assign o_sts.vol_zero   = (r_vol == '0);
    assign o_sts.div_done   = div_done;
    assign o_sts.last_voice = (32'(r_v) == VOICES - 1);
    assign o_sts.out_free   = !o_out_valid || i_out_ready;

endmodule

// ===== rtl/three_voice_square_noise_synth_unit.sv =====
// top level of the three voice square and noise synth
// input channel: i_in_valid / o_in_ready carry one item (a midi event or a
//   sample tick); o_in_ready is high only while the sequencer is idle
// output channel: o_out_valid / i_out_ready carry one sample per tick item,
//   events give none
// config: i_cfg_we writes i_cfg_data into the master volume, reset value 5
// sequence: an event is decoded and applied with no voice pass; a tick
//   runs, for each voice in turn, two 20-bit remainder passes (noise
//   rate, tone phase) on the shared bit-serial divider and adds the
//   voice term to the mix, then scales and loads the sample; zero
//   volume ticks skip the voice passes
// the next item is accepted as soon as a sample sits in the output
//   register, so a stalled receiver holds at most one finished sample
//   and blocks only the next tick at its output step
// reset: synchronous active low, voice state returns to its reset values,
//   no output pending
module three_voice_square_noise_synth_unit import tvsns_pkg::*; #(
    parameter int VOICES        = 3,
    parameter int PITCH_ENTRIES = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_cmd,
    input  logic [7:0]         i_midi_status,
    input  logic [6:0]         i_midi_data1,
    input  logic [6:0]         i_midi_data2,
    input  logic [11:0]        i_sample_index,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_sample,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    tvsns_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    tvsns_dp #(
        .VOICES        (VOICES),
        .PITCH_ENTRIES (PITCH_ENTRIES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_cmd_bit      (i_cmd),
        .i_midi_status  (i_midi_status),
        .i_midi_data1   (i_midi_data1),
        .i_midi_data2   (i_midi_data2),
        .i_sample_index (i_sample_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sample       (o_sample)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("accepted item did not start work");

    a_out_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("sample appeared without an item at work");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.noise_start, cmd.tone_start, cmd.voice_upd, cmd.acc, cmd.out_load}))
        else $error("conflicting datapath commands");

endmodule
